// File: sv/mmpd_pkg.sv
// Shared types, codes and constants of the multi-mode pixel decoder.
// No dependencies; every other file except mmpd_ram refers to this package by scoped names.
package mmpd_pkg;

    localparam int RGB_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int MAX_PIX = 8;
    localparam int PIX_W   = 3;

    typedef enum logic [1:0] {
        MODE_CGA    = 2'd0,
        MODE_GREY   = 2'd1,
        MODE_PLANAR = 2'd2,
        MODE_VGA256 = 2'd3
    } pixel_mode_t;

    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    localparam logic [PIX_W-1:0] LAST_OF_FOUR  = 3'd3;
    localparam logic [PIX_W-1:0] LAST_OF_EIGHT = 3'd7;

    localparam logic [RGB_W-1:0] GREY_0 = 24'h000000;
    localparam logic [RGB_W-1:0] GREY_1 = 24'h444444;
    localparam logic [RGB_W-1:0] GREY_2 = 24'h888888;
    localparam logic [RGB_W-1:0] GREY_3 = 24'hcccccc;

    // One classified item, as handed from the front end to the back end.
    typedef struct packed {
        logic                                is_write;
        logic                                grey;
        logic [PIX_W-1:0]                    last_pix;
        logic [BYTE_W-1:0]                   slot;
        logic [RGB_W-1:0]                    colour;
        logic [MAX_PIX-1:0][BYTE_W-1:0]      idx;
    } entry_t;

    function automatic logic [RGB_W-1:0] grey_level(input logic [1:0] g);
        logic [RGB_W-1:0] v;
        unique case (g)
            2'd0: v = GREY_0;
            2'd1: v = GREY_1;
            2'd2: v = GREY_2;
            2'd3: v = GREY_3;
            default: v = GREY_0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/multi_mode_pixel_decoder_unit.sv
// Top level of the multi-mode pixel decoder: mode register, front end, queue
// and back end. Depends on mmpd_pkg, mmpd_front, mmpd_queue, mmpd_back.
//
// Input beats are palette writes (tuser 0) or four fetched video bytes
// (tuser 1), decoded under pixel_mode into 24-bit RGB pixels, left to right,
// with tlast on the final pixel of each data beat. The front end takes a beat
// every clock while its two-entry queue has room; the back end drains it at
// one palette read per clock while m_tready does not stall the output. With
// the queue empty, the first pixel passes through the queue slot and then the
// output register before it is offered on m_tvalid. The palette clears at
// reset through per-entry valid bits, so there is no clearing pass. Write
// pixel_mode only while the block is idle.
module multi_mode_pixel_decoder_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // palette_slot[7:0], palette_colour[31:8],
                                  // byte_zero[39:32], byte_one[47:40],
                                  // byte_two[55:48], byte_three[63:56]
    input  logic        s_tuser,  // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // pixel_rgb[23:0]
    output logic        m_tlast,  // last_pixel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data  // pixel_mode[1:0]
);

    mmpd_pkg::pixel_mode_t pixel_mode_reg, pixel_mode_next;
    mmpd_pkg::entry_t      front_entry, head_entry;
    logic                  head_valid, pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        pixel_mode_next = pixel_mode_reg;
        if (cfg_valid && cfg_ready) begin
            pixel_mode_next = mmpd_pkg::pixel_mode_t'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_mode_reg <= mmpd_pkg::MODE_VGA256;
        end else begin
            pixel_mode_reg <= pixel_mode_next;
        end
    end

    mmpd_front u_front (
        .mode  (pixel_mode_reg),
        .kind  (s_tuser),
        .data  (s_tdata),
        .entry (front_entry)
    );

    mmpd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_entry (front_entry),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    mmpd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_pop_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> head_valid)
        else $error("queue full but head not valid");

    a_output_follows_head: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(head_valid && !head_entry.is_write))
        else $error("pixel produced without a data item at the queue head");

endmodule

// File: sv/mmpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module mmpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/mmpd_front.sv
// Front end: classifies an input beat and unpacks its pixel indices by mode.
// Depends on mmpd_pkg.
module mmpd_front (
    input  mmpd_pkg::pixel_mode_t mode,
    input  logic                  kind,
    input  logic [63:0]           data,
    output mmpd_pkg::entry_t      entry
);

    logic [7:0] b0, b1, b2, b3;

    assign b0 = data[39:32];
    assign b1 = data[47:40];
    assign b2 = data[55:48];
    assign b3 = data[63:56];

    always_comb begin
        entry          = '0;
        entry.is_write = (kind == mmpd_pkg::KIND_PALETTE);
        entry.slot     = data[7:0];
        entry.colour   = data[31:8];
        unique case (mode)
            mmpd_pkg::MODE_CGA, mmpd_pkg::MODE_GREY: begin
                entry.grey     = (mode == mmpd_pkg::MODE_GREY);
                entry.last_pix = mmpd_pkg::LAST_OF_FOUR;
                // most significant pair is the leftmost pixel
                for (int i = 0; i < 4; i++) begin
                    entry.idx[i] = {6'b0, b0[7-2*i -: 2]};
                end
            end
            mmpd_pkg::MODE_PLANAR: begin
                entry.last_pix = mmpd_pkg::LAST_OF_EIGHT;
                for (int i = 0; i < 8; i++) begin
                    entry.idx[i] = {4'b0, b3[7-i], b2[7-i], b1[7-i], b0[7-i]};
                end
            end
            mmpd_pkg::MODE_VGA256: begin
                entry.last_pix = mmpd_pkg::LAST_OF_FOUR;
                entry.idx[0]   = b0;
                entry.idx[1]   = b1;
                entry.idx[2]   = b2;
                entry.idx[3]   = b3;
            end
            default: begin
                entry.last_pix = mmpd_pkg::LAST_OF_FOUR;
            end
        endcase
    end

endmodule

// File: sv/mmpd_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on mmpd_pkg.
module mmpd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  mmpd_pkg::entry_t push_entry,
    output logic             head_valid,
    output mmpd_pkg::entry_t head_entry,
    input  logic             pop
);

    mmpd_pkg::entry_t slots_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: sv/mmpd_back.sv
// Back end: executes palette writes; walks data items one pixel a clock unless
// stalled, via palette RAM to the output register. Depends on mmpd_pkg, mmpd_ram.
module mmpd_back #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  mmpd_pkg::entry_t head_entry,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [8:0] ENTRY_LIM = 9'(PALETTE_ENTRIES);

    logic [mmpd_pkg::PIX_W-1:0] cnt_reg, cnt_next;
    logic [PALETTE_ENTRIES-1:0] valid_reg, valid_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_last_reg, s1_grey_reg, s1_hit_reg;
    logic [1:0]                 s1_gidx_reg;

    logic                       advance, head_write, issue, is_last;
    logic [7:0]                 cur_idx;
    logic                       rd_in_range, wr_in_range, entry_valid, wr_en;
    logic [AW-1:0]              rd_addr, wr_addr;
    logic [23:0]                rd_data;

    assign advance     = !s1_valid_reg || m_tready;
    assign head_write  = head_valid && head_entry.is_write;
    assign issue       = head_valid && !head_entry.is_write && advance;
    assign cur_idx     = head_entry.idx[cnt_reg];
    assign is_last     = (cnt_reg == head_entry.last_pix);
    assign rd_in_range = ({1'b0, cur_idx} < ENTRY_LIM);
    assign wr_in_range = ({1'b0, head_entry.slot} < ENTRY_LIM);
    assign rd_addr     = cur_idx[AW-1:0];
    assign wr_addr     = head_entry.slot[AW-1:0];
    assign wr_en       = head_write && wr_in_range;
    // a write retires as soon as it is at the head; a data item retires on its last pixel
    assign pop         = head_write || (issue && is_last);

    always_comb begin
        entry_valid = 1'b0;
        valid_next  = valid_reg;
        for (int e = 0; e < PALETTE_ENTRIES; e++) begin
            if (rd_addr == AW'(e)) begin
                entry_valid = valid_reg[e];
            end
            if (wr_en && wr_addr == AW'(e)) begin
                valid_next[e] = 1'b1;
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (issue) begin
            cnt_next = is_last ? '0 : cnt_reg + 1'b1;
        end
        s1_valid_next = advance ? issue : s1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            valid_reg    <= valid_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // hold the pixel tags together with the RAM read register
    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_last_reg <= is_last;
            s1_grey_reg <= head_entry.grey;
            s1_gidx_reg <= cur_idx[1:0];
            s1_hit_reg  <= rd_in_range && entry_valid;
        end
    end

    mmpd_ram #(
        .WIDTH (mmpd_pkg::RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (head_entry.colour),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = s1_valid_reg;
    assign m_tlast  = s1_last_reg;
    assign m_tdata  = s1_grey_reg ? mmpd_pkg::grey_level(s1_gidx_reg)
                    : (s1_hit_reg ? rd_data : '0);

endmodule
